// File: rtl/core/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// Shared widths, command and status codes for the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

  localparam int CMD_W        = 2;
  localparam int KEY_W        = 16;
  localparam int PRIO_W       = 32;
  localparam int ST_W         = 2;
  localparam int ENTRY_W      = KEY_W + PRIO_W;
  localparam int CAPACITY_DEF = 1024;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [PRIO_W-1:0] prio_t;

  localparam cmd_t CMD_INSERT   = 2'd0;
  localparam cmd_t CMD_POP_HIGH = 2'd1;
  localparam cmd_t CMD_POP_LOW  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_DUP   = 2'd3;

endpackage

// File: rtl/core/dep_ram.sv
// ----------------------------------------------------------------------------
// dep_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dep_ram #(
  parameter  int WIDTH = 48,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/double_ended_priority_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top
// Bounded double-ended priority queue kept sorted in one RAM.
// ----------------------------------------------------------------------------
// Entries sit in a single RAM as a circular buffer sorted by ascending
// priority, so both ends are reachable directly: a pop reads the end entry
// into the response register and then the output register. An insert runs a
// binary search (up to ceil(log2(n+1)) probes for n stored entries) and then
// shifts every entry above the insertion point up by one. The entry RAM has one
// read and one write port, which the search comparator and the shift loop share.
// The queue takes no new request until the current one has its result in the
// output register. Refused inserts (full, duplicate priority) leave the queue
// unchanged. No clearing pass is needed after reset.
module double_ended_priority_queue_top
  import dep_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [KEY_W-1:0]  in_entry_key,
  input  logic [PRIO_W-1:0] in_entry_priority,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KEY_W-1:0]  out_key,
  output logic [PRIO_W-1:0] out_priority,
  output logic [ST_W-1:0]   out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW:0]   CAP_X = (CW + 1)'(CAPACITY);

  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE   = 4'd0;
  localparam logic [SW-1:0] S_POPRD  = 4'd1;
  localparam logic [SW-1:0] S_POPDAT = 4'd2;
  localparam logic [SW-1:0] S_SRCH   = 4'd3;
  localparam logic [SW-1:0] S_CMP    = 4'd4;
  localparam logic [SW-1:0] S_SH_RD  = 4'd5;
  localparam logic [SW-1:0] S_SH_WR  = 4'd6;
  localparam logic [SW-1:0] S_PUT    = 4'd7;
  localparam logic [SW-1:0] S_RESP   = 4'd8;

  // logical index -> RAM address, wrapping once past the buffer end
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(idx);
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return sum[AW-1:0];
  endfunction

  logic [SW-1:0]  state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;
  logic [CW-1:0]  j_r, j_nxt;
  cmd_t           cmd_r, cmd_nxt;
  key_t           key_r, key_nxt;
  prio_t          prio_r, prio_nxt;
  key_t           res_key_r, res_key_nxt;
  prio_t          res_prio_r, res_prio_nxt;
  status_t        res_st_r, res_st_nxt;
  logic           out_valid_r, out_valid_nxt;
  key_t           out_key_r, out_key_nxt;
  prio_t          out_prio_r, out_prio_nxt;
  status_t        out_st_r, out_st_nxt;

  logic [CW-1:0]      rd_idx, wr_idx;
  logic [AW-1:0]      rd_phys, wr_phys;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  key_t               rd_key;
  prio_t              rd_prio;
  logic               prio_lt, prio_eq;

  assign rd_phys = phys(head_r, rd_idx);
  assign wr_phys = phys(head_r, wr_idx);
  assign mid_sum = (CW + 1)'(lo_r) + (CW + 1)'(hi_r);
  assign mid     = mid_sum[CW:1];
  assign rd_key  = ram_rdata[ENTRY_W-1:PRIO_W];
  assign rd_prio = ram_rdata[PRIO_W-1:0];
  // shared priority comparator
  assign prio_lt = rd_prio < prio_r;
  assign prio_eq = rd_prio == prio_r;

  dep_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_phys),
    .wdata (ram_wdata),
    .raddr (rd_phys),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    prio_nxt      = prio_r;
    res_key_nxt   = res_key_r;
    res_prio_nxt  = res_prio_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_prio_nxt  = out_prio_r;
    out_st_nxt    = out_st_r;
    rd_idx        = '0;
    wr_idx        = '0;
    ram_we        = 1'b0;
    ram_wdata     = {key_r, prio_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_command;
          key_nxt      = in_entry_key;
          prio_nxt     = in_entry_priority;
          res_key_nxt  = '0;
          res_prio_nxt = '0;
          res_st_nxt   = ST_OK;
          case (in_command)
            CMD_INSERT: begin
              if (count_r == CAP_C) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = count_r;
                state_nxt = S_SRCH;
              end
            end
            CMD_POP_HIGH, CMD_POP_LOW: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_POPRD;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_POPRD: begin
        rd_idx    = (cmd_r == CMD_POP_HIGH) ? count_r - CW'(1) : '0;
        state_nxt = S_POPDAT;
      end
      S_POPDAT: begin
        res_key_nxt  = rd_key;
        res_prio_nxt = rd_prio;
        count_nxt    = count_r - CW'(1);
        if (cmd_r == CMD_POP_LOW) begin
          rd_idx   = CW'(1);
          head_nxt = rd_phys;
        end
        state_nxt = S_RESP;
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_idx    = mid;
          state_nxt = S_CMP;
        end else if (lo_r < count_r) begin
          j_nxt     = count_r - CW'(1);
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_CMP: begin
        // an equal priority is always probed before the search ends
        if (prio_eq) begin
          res_st_nxt = ST_DUP;
          state_nxt  = S_RESP;
        end else begin
          if (prio_lt) begin
            lo_nxt = mid + CW'(1);
          end else begin
            hi_nxt = mid;
          end
          state_nxt = S_SRCH;
        end
      end
      S_SH_RD: begin
        rd_idx    = j_r;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_idx    = j_r + CW'(1);
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (j_r == lo_r) begin
          state_nxt = S_PUT;
        end else begin
          j_nxt     = j_r - CW'(1);
          state_nxt = S_SH_RD;
        end
      end
      S_PUT: begin
        wr_idx    = lo_r;
        ram_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = res_key_r;
          out_prio_nxt  = res_prio_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    j_r        <= j_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    prio_r     <= prio_nxt;
    res_key_r  <= res_key_nxt;
    res_prio_r <= res_prio_nxt;
    res_st_r   <= res_st_nxt;
    out_key_r  <= out_key_nxt;
    out_prio_r <= out_prio_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_key      = out_key_r;
  assign out_priority = out_prio_r;
  assign out_status   = out_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(head_r) < CAP_X)
    else $error("head pointer out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_CMP) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("search window out of range");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the queue");

endmodule
